@@ rtl/cpe_pkg.sv @@
// Shared types, constants and cell decode for the crossbar path evaluator.
package cpe_pkg;

    // Fixed field widths
    localparam int CELL_W   = 6;
    localparam int CFG_W    = 5;
    localparam int VAR_W    = 16;
    localparam int ROW_IN_W = 4;
    localparam int COL_IN_W = 4;
    localparam int IDX_W    = 4;
    localparam int KIND_W   = 2;

    // Size register reset value
    localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

    // Configuration register indexes
    localparam logic REG_USED_ROWS = 1'b0;
    localparam logic REG_USED_COLS = 1'b1;

    // Transaction opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_EVAL = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_OFF,
        KIND_ON,
        KIND_VAR,
        KIND_NVAR
    } cell_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_SPREAD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic begin_eval;
        logic read_row;
        logic init_masks;
        logic step_masks;
        logic finish;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic row_last;
        logic settled;
    } dp_status_t;

    // Decide whether one stored cell conducts under the given variable values
    function automatic logic cell_on(
        input logic [CELL_W-1:0] cell_bits,
        input logic [VAR_W-1:0]  vals
    );
        logic v;
        logic res;
        v = vals[cell_bits[CELL_W-1:KIND_W]];
        case (cell_bits[KIND_W-1:0])
            KIND_OFF:  res = 1'b0;
            KIND_ON:   res = 1'b1;
            KIND_VAR:  res = v;
            KIND_NVAR: res = ~v;
            default:   res = 1'b0;
        endcase
        return res;
    endfunction

endpackage

@@ rtl/cpe_ctrl.sv @@
// Controller state machine: sequences load, row sweep and spreading passes.
module cpe_ctrl
    import cpe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic       op,
    output logic       busy,
    output dp_cmd_t    cmd,
    input  dp_status_t status
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (op == OP_EVAL)
                    begin
                        cmd.begin_eval = 1'b1;
                        state_next     = S_READ;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            S_READ:
            begin
                cmd.read_row = 1'b1;
                if (status.row_last)
                begin
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                // last row lands in the cell map at this edge
                cmd.init_masks = 1'b1;
                state_next     = S_SPREAD;
            end
            S_SPREAD:
            begin
                cmd.step_masks = 1'b1;
                if (status.settled)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

@@ rtl/cpe_datapath.sv @@
// Datapath: cell memory, conducting-cell map, row/column reach masks, result.
module cpe_datapath
    import cpe_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  dp_cmd_t             cmd,
    output dp_status_t          status,
    input  logic [CFG_W-1:0]    used_rows,
    input  logic [CFG_W-1:0]    used_cols,
    input  logic [ROW_IN_W-1:0] cell_row,
    input  logic [COL_IN_W-1:0] cell_col,
    input  logic [KIND_W-1:0]   cell_kind,
    input  logic [IDX_W-1:0]    var_index,
    input  logic [VAR_W-1:0]    var_values,
    output logic                done,
    output logic                path_found
);

    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ROW_BITS = MAX_COLS * CELL_W;

    // Cell memory: one row of cells per address
    logic [ROW_BITS-1:0] mem [MAX_ROWS];

    logic [ROW_AW-1:0]   row_cnt_reg;
    logic [ROW_BITS-1:0] rd_data_reg;
    logic                cap_valid_reg;
    logic [ROW_AW-1:0]   cap_row_reg;
    logic [VAR_W-1:0]    vals_reg;
    logic [MAX_COLS-1:0] on_reg [MAX_ROWS];
    logic [MAX_ROWS-1:0] rmask_reg;
    logic [MAX_COLS-1:0] cmask_reg;
    logic                done_reg;
    logic                path_found_reg;

    logic [MAX_ROWS-1:0] rmask_next;
    logic [MAX_COLS-1:0] cmask_next;
    logic [MAX_COLS-1:0] hit [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_valid;
    logic [MAX_COLS-1:0] col_valid;
    logic [RCNT_W-1:0]   nr_eff;
    logic [CCNT_W-1:0]   nc_eff;
    logic [ROW_AW-1:0]   last_row;
    logic                size_ok;
    logic                wr_in_range;
    logic [ROW_AW-1:0]   wr_row;
    logic [COL_AW-1:0]   wr_col;
    logic [MAX_COLS-1:0] row_on;

    // Clamp sizes to the grid
    assign nr_eff = (32'(used_rows) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(used_rows);
    assign nc_eff = (32'(used_cols) > MAX_COLS) ? CCNT_W'(MAX_COLS) : CCNT_W'(used_cols);
    assign size_ok  = (nr_eff != '0) && (nc_eff != '0);
    assign last_row = ROW_AW'(nr_eff - RCNT_W'(1));

    always_comb
    begin
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            row_valid[r] = (r < int'(nr_eff));
        end
        for (int c = 0; c < MAX_COLS; c++)
        begin
            col_valid[c] = (c < int'(nc_eff));
        end
    end

    // Load address decode; drop loads outside the grid
    assign wr_in_range = (32'(cell_row) < MAX_ROWS) && (32'(cell_col) < MAX_COLS);
    assign wr_row      = ROW_AW'(cell_row);
    assign wr_col      = COL_AW'(cell_col);

    // Memory write and registered row read
    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_in_range)
        begin
            mem[wr_row][wr_col*CELL_W +: CELL_W] <= {var_index, cell_kind};
        end
        if (cmd.read_row)
        begin
            rd_data_reg <= mem[row_cnt_reg];
        end
    end

    // Row sweep counter and capture pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_cnt_reg   <= '0;
            cap_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.begin_eval)
            begin
                row_cnt_reg <= '0;
            end
            else if (cmd.read_row)
            begin
                row_cnt_reg <= row_cnt_reg + ROW_AW'(1);
            end
            cap_valid_reg <= cmd.read_row;
        end
    end

    always_ff @(posedge clk)
    begin
        cap_row_reg <= row_cnt_reg;
        if (cmd.begin_eval)
        begin
            vals_reg <= var_values;
        end
    end

    // Decode one row of cells into conduct bits
    always_comb
    begin
        for (int c = 0; c < MAX_COLS; c++)
        begin
            row_on[c] = cell_on(rd_data_reg[c*CELL_W +: CELL_W], vals_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cap_valid_reg)
        begin
            on_reg[cap_row_reg] <= row_on;
        end
    end

    // One spreading pass over all cells
    always_comb
    begin
        rmask_next = rmask_reg;
        cmask_next = cmask_reg;
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                hit[r][c] = on_reg[r][c] & row_valid[r] & col_valid[c]
                          & (rmask_reg[r] | cmask_reg[c]);
            end
        end
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            rmask_next[r] = rmask_reg[r] | (|hit[r]);
            for (int c = 0; c < MAX_COLS; c++)
            begin
                cmask_next[c] = cmask_next[c] | hit[r][c];
            end
        end
    end

    assign status.settled  = (rmask_next == rmask_reg) && (cmask_next == cmask_reg);
    assign status.row_last = (row_cnt_reg == ROW_AW'(MAX_ROWS - 1));

    // Reach masks: row 0 seeds the search
    always_ff @(posedge clk)
    begin
        if (cmd.init_masks)
        begin
            rmask_reg <= MAX_ROWS'(1);
            cmask_reg <= '0;
        end
        else if (cmd.step_masks)
        begin
            rmask_reg <= rmask_next;
            cmask_reg <= cmask_next;
        end
    end

    // Result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            path_found_reg <= size_ok & (|hit[last_row]);
        end
    end

    assign done       = done_reg;
    assign path_found = path_found_reg;

endmodule

@@ rtl/crossbar_path_evaluator_core.sv @@
// Top level of the crossbar path evaluator: size registers, controller, datapath.
// Load transaction: written at the clock edge that samples start, busy stays low, no result.
// Evaluate transaction: busy through the row sweep, one wait state and the spreading passes;
// done pulses with busy low, registered from the controller's finish command.
// Rate is set by the one-row-per-cycle sweep of the cell memory and one pass per cycle.
// Reset clears control and sets both sizes to 16; cell memory is undefined until loaded.
module crossbar_path_evaluator_core
    import cpe_pkg::*;
#(
    parameter int MAX_ROWS = 16,
    parameter int MAX_COLS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                op,
    input  logic [ROW_IN_W-1:0] cell_row,
    input  logic [COL_IN_W-1:0] cell_col,
    input  logic [KIND_W-1:0]   cell_kind,
    input  logic [IDX_W-1:0]    var_index,
    input  logic [VAR_W-1:0]    var_values,
    output logic                done,
    output logic                path_found,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data
);

    logic [CFG_W-1:0] used_rows_reg;
    logic [CFG_W-1:0] used_cols_reg;
    dp_cmd_t          cmd;
    dp_status_t       status;

    // Size registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_rows_reg <= SIZE_RESET;
            used_cols_reg <= SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_USED_ROWS: used_rows_reg <= cfg_data;
                REG_USED_COLS: used_cols_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    cpe_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .busy   (busy),
        .cmd    (cmd),
        .status (status)
    );

    cpe_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .used_rows  (used_rows_reg),
        .used_cols  (used_cols_reg),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cell_kind  (cell_kind),
        .var_index  (var_index),
        .var_values (var_values),
        .done       (done),
        .path_found (path_found)
    );

    // An evaluate transaction keeps the block busy in the next cycle
    a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_EVAL) |=> busy)
        else $error("evaluate accepted but block not busy");

    // A load transaction never produces a result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && op == OP_LOAD) |=> !done)
        else $error("result strobe after a load");

    // A result follows only the end of an evaluation
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && $past(busy)))
        else $error("result strobe without a finished evaluation");

endmodule
